// ===== rtl/core/iteration_count_color_gradient_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the iteration-count colour gradient
// Shared property wrappers: clocked, disabled in reset, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef ITERATION_COUNT_COLOR_GRADIENT_DEFINES_SVH
`define ITERATION_COUNT_COLOR_GRADIENT_DEFINES_SVH

// Same-cycle implication.
`define IGC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IGC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/igc_pkg.sv =====
// ----------------------------------------------------------------------------
// igc_pkg
// Constants and helpers for the iteration-count colour gradient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package igc_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic [15:0] MAX_ITER_RESET = 16'd256;

  // Colour words, 0xRRGGBBAA
  localparam logic [31:0] COLOR_BLACK = 32'h0000_00FF;
  localparam logic [31:0] COLOR_WHITE = 32'hFFFF_FFFF;
  localparam logic [31:0] BASE_RAMP1  = 32'h0000_00FF;
  localparam logic [31:0] BASE_RAMP2  = 32'h0000_FFFF;
  localparam logic [31:0] BASE_RAMP3  = 32'hFF00_FFFF;

  // One radix-4 step of a divide by three: val = {rem, digit}, val < 12.
  // Returns {quotient digit, new remainder}.
  function automatic logic [3:0] igc_div3_digit(input logic [3:0] val);
    logic [1:0] q;
    logic [3:0] r;
    begin
      if (val >= 4'd9) begin
        q = 2'd3;
      end else if (val >= 4'd6) begin
        q = 2'd2;
      end else if (val >= 4'd3) begin
        q = 2'd1;
      end else begin
        q = 2'd0;
      end
      r = val - {1'b0, q, 1'b0} - {2'b00, q};
      return {q, r[1:0]};
    end
  endfunction

endpackage

// ===== rtl/core/iteration_count_color_gradient.sv =====
// ----------------------------------------------------------------------------
// iteration_count_color_gradient
// A pixel passes the states PREP, DIV3 (radix-4 divide-by-three pass), SEL, DIV
//   (9-step restoring divider) and DONE; black or white pixels go from PREP to DONE.
// A new pixel is taken only once the last result is in the output register
//   (in_stall stays high outside ST_IDLE).
// Reset (rst, synchronous): range 0..0, trackers empty, max_iterations 256.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iteration_count_color_gradient #(
  parameter int COUNT_WIDTH = igc_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // pixel input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] iteration_count,
  input  logic        frame_start,
  // colour output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] color,
  // max_iterations write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] max_iterations
);

  import igc_pkg::*;

  // Widths. Span is padded to an even number of bits for the radix-4 pass.
  localparam int W     = COUNT_WIDTH;
  localparam int DIG   = (W + 1) / 2;
  localparam int SW    = 2 * DIG;
  localparam int CW3   = $clog2(DIG + 1);
  localparam int NUM_W = W + 10;   // 768 * offset
  localparam int DSH_W = W + 9;    // divisor << 8

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_DIV3 = 6'b000100,
    ST_SEL  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    MODE_BLACK,
    MODE_WHITE,
    MODE_RAMP1,
    MODE_RAMP2,
    MODE_RAMP3
  } mode_t;

  state_t state;
  mode_t  mode;

  // Configuration and frame statistics
  logic [W-1:0] iter_limit;
  logic [W-1:0] range_low;
  logic [W-1:0] range_high;
  logic [W-1:0] track_low;
  logic [W-1:0] track_high;

  // Per-pixel working registers
  logic [W-1:0]     count;
  logic [W-1:0]     span;
  logic [W-1:0]     offset;
  logic [SW-1:0]    span_sh;    // span digits, MSB first
  logic [SW-1:0]    third;      // floor(span/3), built digit by digit
  logic [1:0]       rem3;       // span mod 3 once the pass is over
  logic [CW3-1:0]   cnt3;
  logic [NUM_W-1:0] rem;
  logic [DSH_W-1:0] dsh;
  logic [8:0]       quo;
  logic [3:0]       cntd;

  logic in_fire;
  logic out_free;

  assign in_stall  = (state != ST_IDLE);
  // writes only when idle and no pixel is offered in the same cycle
  assign cfg_ready = (state == ST_IDLE) && !in_valid;
  assign in_fire   = in_valid && !in_stall;
  // output register can take a new result this cycle
  assign out_free  = !out_valid || !out_stall;

  // --------------------------------------------------------------------------
  // Frame-start swap and tracker update, applied at the input transaction.
  // --------------------------------------------------------------------------
  logic [W-1:0] count_in;
  logic [W-1:0] track_low_base;
  logic [W-1:0] track_high_base;
  logic [W-1:0] track_low_next;
  logic [W-1:0] track_high_next;

  always_comb begin
    count_in        = W'(iteration_count);
    track_low_base  = frame_start ? iter_limit : track_low;
    track_high_base = frame_start ? '0 : track_high;
    track_low_next  = (count_in < track_low_base) ? count_in : track_low_base;
    track_high_next = ((count_in > track_high_base) && (count_in != iter_limit)) ?
                      count_in : track_high_base;
  end

  // --------------------------------------------------------------------------
  // Preparation: span, offset, black and white short cuts.
  // --------------------------------------------------------------------------
  logic [W:0]   span_s;
  logic         span_pos;
  logic [W-1:0] offset_next;

  always_comb begin
    span_s      = {1'b0, range_high} - {1'b0, range_low};
    span_pos    = !span_s[W] && (span_s[W-1:0] != '0);
    offset_next = (count > range_low) ? (count - range_low) : '0;
  end

  // --------------------------------------------------------------------------
  // Divide-by-three digit step
  // --------------------------------------------------------------------------
  logic [3:0] d3_out;

  assign d3_out = igc_div3_digit({rem3, span_sh[SW-1 -: 2]});

  // --------------------------------------------------------------------------
  // Ramp selection: a = span/3, b = 2*span/3 = 2a + (r == 2).
  // Second third divisor 2*span - 3a reduces to span + r,
  // last third divisor span - b.
  // --------------------------------------------------------------------------
  logic [W-1:0]     a_th;
  logic [W:0]       b_full;
  logic [W-1:0]     b_th;
  logic [W-1:0]     ramp_x;
  logic [W:0]       ramp_den;
  logic [NUM_W-1:0] ramp_num;
  mode_t            ramp_mode;

  always_comb begin
    a_th   = third[W-1:0];
    b_full = {a_th, 1'b0} + {{W{1'b0}}, (rem3 == 2'd2)};
    b_th   = b_full[W-1:0];
    if (offset < a_th) begin
      ramp_mode = MODE_RAMP1;
      ramp_x    = offset;
      ramp_den  = {1'b0, span};
    end else if (offset < b_th) begin
      ramp_mode = MODE_RAMP2;
      ramp_x    = offset - a_th;
      ramp_den  = {1'b0, span} + {{(W - 1){1'b0}}, rem3};
    end else begin
      ramp_mode = MODE_RAMP3;
      ramp_x    = offset - b_th;
      ramp_den  = {1'b0, span - b_th};
    end
    // 768x for the first two ramps, 256x for the last
    if (ramp_mode == MODE_RAMP3) begin
      ramp_num = {2'b00, ramp_x, 8'h00};
    end else begin
      ramp_num = {1'b0, ramp_x, 9'h000} + {2'b00, ramp_x, 8'h00};
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider step; quo[8] set means the quotient reached 256.
  // --------------------------------------------------------------------------
  logic div_ge;

  assign div_ge = (rem >= {1'b0, dsh});

  // --------------------------------------------------------------------------
  // Colour assembly
  // --------------------------------------------------------------------------
  logic [7:0]  shade;
  logic [31:0] color_next;

  always_comb begin
    shade = quo[8] ? 8'hFF : quo[7:0];
    unique case (mode)
      MODE_BLACK: color_next = COLOR_BLACK;
      MODE_WHITE: color_next = COLOR_WHITE;
      MODE_RAMP1: color_next = BASE_RAMP1 | {16'h0000, shade, 8'h00};
      MODE_RAMP2: color_next = BASE_RAMP2 | {shade, 24'h000000};
      MODE_RAMP3: color_next = BASE_RAMP3 | {8'h00, shade, 16'h0000};
      default:    color_next = COLOR_WHITE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control and datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      iter_limit <= W'(MAX_ITER_RESET);
      range_low  <= '0;
      range_high <= '0;
      track_low  <= '1;
      track_high <= '0;
    end else begin
      // in ST_DONE the output register is reloaded below instead
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        iter_limit <= W'(max_iterations);
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            count      <= count_in;
            track_low  <= track_low_next;
            track_high <= track_high_next;
            if (frame_start) begin
              range_low  <= track_low;
              range_high <= track_high;
            end
            state <= ST_PREP;
          end
        end

        ST_PREP: begin
          span    <= span_s[W-1:0];
          offset  <= offset_next;
          span_sh <= SW'(span_s[W-1:0]);
          third   <= '0;
          rem3    <= 2'd0;
          cnt3    <= CW3'(DIG);
          if (count == iter_limit) begin
            mode  <= MODE_BLACK;
            state <= ST_DONE;
          end else if (!span_pos) begin
            mode  <= MODE_WHITE;
            state <= ST_DONE;
          end else begin
            state <= ST_DIV3;
          end
        end

        ST_DIV3: begin
          third   <= {third[SW-3:0], d3_out[3:2]};
          rem3    <= d3_out[1:0];
          span_sh <= {span_sh[SW-3:0], 2'b00};
          cnt3    <= cnt3 - CW3'(1);
          if (cnt3 == CW3'(1)) begin
            state <= ST_SEL;
          end
        end

        ST_SEL: begin
          mode  <= ramp_mode;
          rem   <= ramp_num;
          dsh   <= {ramp_den, 8'h00};
          quo   <= '0;
          cntd  <= 4'd9;
          state <= ST_DIV;
        end

        ST_DIV: begin
          if (div_ge) begin
            rem <= rem - {1'b0, dsh};
          end
          quo  <= {quo[7:0], div_ge};
          dsh  <= {1'b0, dsh[DSH_W-1:1]};
          cntd <= cntd - 4'd1;
          if (cntd == 4'd1) begin
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (out_free) begin
            color     <= color_next;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/igc_checker.sv =====
// ----------------------------------------------------------------------------
// igc_checker
// Port-level checks for the iteration-count colour gradient, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "iteration_count_color_gradient_defines.svh"

module igc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] color,
  input logic        cfg_ready
);

  `IGC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(color), "stalled colour transaction changed")

  `IGC_ASSERT_IMP(a_alpha, clk, rst, out_valid, color[7:0] == 8'hFF,
    "alpha byte not opaque")

  `IGC_ASSERT_NXT(a_busy, clk, rst, in_valid && !in_stall, in_stall && !cfg_ready,
    "block not busy after pixel transaction")

  `IGC_ASSERT_IMP(a_result_src, clk, rst, $rose(out_valid), $past(in_stall),
    "result appeared with no pixel in flight")

endmodule

bind iteration_count_color_gradient igc_checker u_igc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .color     (color),
  .cfg_ready (cfg_ready)
);
